>>> rtl/scla_pkg.sv
// scla_pkg: shared types and constants for the line admission filter.
// No dependencies; used by sketch_cache_line_admission_top.
package scla_pkg;

    localparam int SKETCH_BLOCKS = 1024;
    localparam int SLOTS_PER_KEY = 4;
    localparam int BLOCK_BITS    = 512;
    localparam int BLOCK_NIBS    = 128;

    localparam logic [63:0] GOLDEN   = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] MIX_C1   = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] MIX_C2   = 64'h94d049bb133111eb;
    localparam logic [3:0]  NIB_MAX  = 4'd15;

    // per-slot seeds: GOLDEN * (i + 1), wrapping at 64 bits
    localparam logic [63:0] SLOT_SEED [SLOTS_PER_KEY] = '{
        64'(GOLDEN * 64'd1), 64'(GOLDEN * 64'd2),
        64'(GOLDEN * 64'd3), 64'(GOLDEN * 64'd4)
    };

    localparam logic [1:0] OP_QUERY  = 2'd0;
    localparam logic [1:0] OP_HIT    = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [2:0] CFG_LINE_BYTES = 3'd0;
    localparam logic [2:0] CFG_AGING_PER  = 3'd1;
    localparam logic [2:0] CFG_MIN_ACC    = 3'd2;
    localparam logic [2:0] CFG_HIT_TIME   = 3'd3;
    localparam logic [2:0] CFG_FILL_TIME  = 3'd4;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [63:0] byte_pos;
        logic [31:0] bypass_time_ns;
    } t_item;

    typedef struct packed {
        logic        admit;
        logic [3:0]  estimate;
        logic [63:0] admissions;
        logic [63:0] bypasses;
        logic [63:0] thr_bypasses;
        logic [63:0] age_count;
    } t_result;

endpackage

>>> rtl/scla_ram.sv
// scla_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module scla_ram #(
    parameter int WIDTH = 512,
    parameter int DEPTH = 1024,
    parameter int ABITS = 10
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [ABITS-1:0] i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [ABITS-1:0] i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

>>> rtl/sketch_cache_line_admission_top.sv
// sketch_cache_line_admission_top: line admission filter over a blocked
// count-min sketch. Depends on scla_pkg and scla_ram.
//
// Usage: pulse start with an item while busy is low. Query and hit items keep
// busy high through a 64-step bit-serial divide for the key, five 64-bit
// mixer hashes on one shared 32x32 multiplier (the block index is the low
// bits of the first hash), a read and a write of one 512-bit sketch row, a
// read and a write of one more row when an aging step falls due, and a
// closing step. Clear holds busy while it zeroes the sketch, one row zeroed
// per cycle; an unused opcode goes straight to the closing step. After reset
// the block holds busy high while it zeroes the sketch. Each result word is
// shown for one cycle on o_result with o_done high, in the first cycle after
// busy drops; it cannot be held off, so capture it then. Config writes are
// always accepted (o_cfg_ready is tied high) and must only happen while busy
// is low.
module sketch_cache_line_admission_top (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  scla_pkg::t_item          i_item,
    output logic                     o_done,
    output scla_pkg::t_result        o_result,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [2:0]               i_cfg_index,
    input  logic [31:0]              i_cfg_data
);
    import scla_pkg::*;

    localparam int ABITS = $clog2(SKETCH_BLOCKS);

    typedef enum logic [11:0] {
        ST_SWEEP  = 12'b000000000001,
        ST_IDLE   = 12'b000000000010,
        ST_DIV    = 12'b000000000100,
        ST_HADD   = 12'b000000001000,
        ST_HXOR   = 12'b000000010000,
        ST_HMUL   = 12'b000000100000,
        ST_RD     = 12'b000001000000,
        ST_UPD    = 12'b000010000000,
        ST_AGE_RD = 12'b000100000000,
        ST_AGE_WR = 12'b001000000000,
        ST_DONE   = 12'b010000000000,
        ST_SPARE  = 12'b100000000000
    } t_state;

    t_state r_state;

    // configuration
    logic [30:0] r_line_bytes;
    logic [23:0] r_aging_per;
    logic [3:0]  r_min_acc;
    logic [31:0] r_hit_time;
    logic [31:0] r_fill_time;

    // item and sequencer state
    logic [1:0]  r_op;
    logic [31:0] r_bypass;
    logic        r_clr_op;
    logic [63:0] r_q;            // dividend shifting out, quotient shifting in
    logic [31:0] r_rem;
    logic [31:0] r_d;
    logic [5:0]  r_cnt;
    logic [63:0] r_key;
    logic [63:0] r_v;
    logic [63:0] r_acc;
    logic [1:0]  r_mp;           // multiply partial product phase
    logic [1:0]  r_xp;           // mixer round
    logic [2:0]  r_hidx;         // 0 block hash, 1..4 slot hashes
    logic [6:0]  r_slot [SLOTS_PER_KEY];
    logic [ABITS-1:0] r_blk;
    logic [ABITS-1:0] r_swp;
    logic [3:0]  r_est;

    logic [23:0] r_phase;
    logic [9:0]  r_cursor;
    logic [63:0] r_admit_tot;
    logic [63:0] r_bypass_tot;
    logic [63:0] r_benefit_tot;
    logic [63:0] r_aging_tot;

    t_result r_out;
    logic    r_done;

    // RAM ports
    logic                  ram_we;
    logic [ABITS-1:0]      ram_waddr;
    logic [ABITS-1:0]      ram_raddr;
    logic [BLOCK_BITS-1:0] ram_wdata;
    logic [BLOCK_BITS-1:0] ram_rdata;

    scla_ram #(
        .WIDTH (BLOCK_BITS),
        .DEPTH (SKETCH_BLOCKS),
        .ABITS (ABITS)
    ) u_sketch (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign busy        = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_done      = r_done;
    assign o_result    = r_out;

    // bit-serial restoring divider step
    logic [31:0] div_r2;
    logic        div_ge;
    logic [31:0] n_rem;
    logic [63:0] n_q;
    always_comb begin
        div_r2 = {r_rem[30:0], r_q[63]};
        div_ge = (div_r2 >= r_d);
        n_rem  = div_ge ? (div_r2 - r_d) : div_r2;
        n_q    = {r_q[62:0], div_ge};
    end

    // hash input and mixer xor-shift
    logic [63:0] hash_in;
    logic [63:0] mix_t;
    always_comb begin
        hash_in = (r_hidx == 3'd0) ? r_key
                : (r_key ^ SLOT_SEED[2'(r_hidx - 3'd1)]);
        case (r_xp)
            2'd0:    mix_t = r_v ^ (r_v >> 30);
            2'd1:    mix_t = r_v ^ (r_v >> 27);
            default: mix_t = r_v ^ (r_v >> 31);
        endcase
    end

    // shared 32x32 multiplier; low 64 bits of v * C built from three products
    logic [63:0] mul_c;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] mul_p;
    logic [63:0] n_acc;
    always_comb begin
        mul_c = (r_xp == 2'd0) ? MIX_C1 : MIX_C2;
        mul_a = (r_mp == 2'd1) ? r_v[63:32] : r_v[31:0];
        mul_b = (r_mp == 2'd2) ? mul_c[63:32] : mul_c[31:0];
        mul_p = mul_a * mul_b;
        n_acc = (r_mp == 2'd0) ? mul_p : (r_acc + {mul_p[31:0], 32'd0});
    end

    // sketch row update: min of four slots, raise equal ones unless saturated
    logic [3:0]            nib_v [SLOTS_PER_KEY];
    logic [3:0]            upd_est;
    logic [BLOCK_BITS-1:0] upd_row;
    logic [BLOCK_BITS-1:0] age_row;
    always_comb begin
        upd_est = NIB_MAX;
        for (int i = 0; i < SLOTS_PER_KEY; i++) begin
            nib_v[i] = ram_rdata[4*r_slot[i] +: 4];
            if (nib_v[i] < upd_est) begin
                upd_est = nib_v[i];
            end
        end
        upd_row = ram_rdata;
        for (int k = 0; k < BLOCK_NIBS; k++) begin
            if (upd_est != NIB_MAX && ram_rdata[4*k +: 4] == upd_est &&
                (r_slot[0] == 7'(k) || r_slot[1] == 7'(k) ||
                 r_slot[2] == 7'(k) || r_slot[3] == 7'(k))) begin
                upd_row[4*k +: 4] = upd_est + 4'd1;
            end
            age_row[4*k +: 4] = {1'b0, ram_rdata[4*k+1 +: 3]};
        end
    end

    // RAM port muxing
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_swp;
        ram_wdata = '0;
        ram_raddr = r_blk;
        unique case (r_state)
            ST_SWEEP: begin
                ram_we = 1'b1;
            end
            ST_UPD: begin
                ram_we    = 1'b1;
                ram_waddr = r_blk;
                ram_wdata = upd_row;
            end
            ST_AGE_RD: begin
                ram_raddr = ABITS'(r_cursor);
            end
            ST_AGE_WR: begin
                ram_we    = 1'b1;
                ram_waddr = ABITS'(r_cursor);
                ram_wdata = age_row;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    // aging due and admission test
    logic [23:0] per_eff;
    logic        age_due;
    logic [31:0] saving;
    logic [31:0] extra;
    logic [35:0] benefit;
    logic        thr;
    logic        ok;
    logic        is_query;
    always_comb begin
        per_eff  = (r_aging_per == 24'd0) ? 24'd1 : r_aging_per;
        age_due  = ({1'b0, r_phase} + 25'd1) >= {1'b0, per_eff};
        saving   = (r_bypass > r_hit_time) ? (r_bypass - r_hit_time) : 32'd0;
        extra    = (r_fill_time > r_bypass) ? (r_fill_time - r_bypass) : 32'd0;
        benefit  = {32'd0, r_est} * {4'd0, saving};
        thr      = ({1'b0, r_est} + 5'd1) >= {1'b0, r_min_acc};
        ok       = (r_min_acc == 4'd1) ||
                   (thr && r_est != 4'd0 && saving != 32'd0 &&
                    benefit >= {4'd0, extra});
        is_query = (r_op == OP_QUERY);
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_bytes <= 31'd65536;
            r_aging_per  <= 24'd1024;
            r_min_acc    <= 4'd2;
            r_hit_time   <= '0;
            r_fill_time  <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_LINE_BYTES: r_line_bytes <= i_cfg_data[30:0];
                CFG_AGING_PER:  r_aging_per  <= i_cfg_data[23:0];
                CFG_MIN_ACC:    r_min_acc    <= i_cfg_data[3:0];
                CFG_HIT_TIME:   r_hit_time   <= i_cfg_data;
                CFG_FILL_TIME:  r_fill_time  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_SWEEP;
            r_swp         <= '0;
            r_clr_op      <= 1'b0;
            r_done        <= 1'b0;
            r_phase       <= '0;
            r_cursor      <= '0;
            r_admit_tot   <= '0;
            r_bypass_tot  <= '0;
            r_benefit_tot <= '0;
            r_aging_tot   <= '0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                ST_SWEEP: begin
                    r_swp <= r_swp + 1'b1;
                    if (r_swp == ABITS'(SKETCH_BLOCKS - 1)) begin
                        r_swp   <= '0;
                        r_state <= r_clr_op ? ST_DONE : ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (start) begin
                        r_op     <= i_item.opcode;
                        r_bypass <= i_item.bypass_time_ns;
                        r_est    <= '0;
                        r_clr_op <= 1'b0;
                        if (i_item.opcode == OP_QUERY || i_item.opcode == OP_HIT) begin
                            r_q     <= i_item.byte_pos;
                            r_rem   <= '0;
                            r_d     <= (r_line_bytes == 31'd0) ? 32'd1
                                                              : {1'b0, r_line_bytes};
                            r_cnt   <= '0;
                            r_state <= ST_DIV;
                        end else if (i_item.opcode == OP_CLEAR) begin
                            r_clr_op <= 1'b1;
                            r_phase  <= '0;
                            r_cursor <= '0;
                            r_swp    <= '0;
                            r_state  <= ST_SWEEP;
                        end else begin
                            r_state <= ST_DONE;
                        end
                    end
                end
                ST_DIV: begin
                    r_q   <= n_q;
                    r_rem <= n_rem;
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'd63) begin
                        r_key   <= n_q;
                        r_hidx  <= 3'd0;
                        r_state <= ST_HADD;
                    end
                end
                ST_HADD: begin
                    r_v     <= hash_in + GOLDEN;
                    r_xp    <= 2'd0;
                    r_state <= ST_HXOR;
                end
                ST_HXOR: begin
                    if (r_xp == 2'd2) begin
                        if (r_hidx == 3'd0) begin
                            // block count is a power of two: index is the low bits
                            r_blk   <= mix_t[ABITS-1:0];
                            r_hidx  <= 3'd1;
                            r_state <= ST_HADD;
                        end else begin
                            r_slot[2'(r_hidx - 3'd1)] <= mix_t[6:0];
                            if (r_hidx == 3'(SLOTS_PER_KEY)) begin
                                r_state <= ST_RD;
                            end else begin
                                r_hidx  <= r_hidx + 3'd1;
                                r_state <= ST_HADD;
                            end
                        end
                    end else begin
                        r_v     <= mix_t;
                        r_mp    <= 2'd0;
                        r_state <= ST_HMUL;
                    end
                end
                ST_HMUL: begin
                    r_acc <= n_acc;
                    r_mp  <= r_mp + 2'd1;
                    if (r_mp == 2'd2) begin
                        r_v     <= n_acc;
                        r_xp    <= r_xp + 2'd1;
                        r_state <= ST_HXOR;
                    end
                end
                ST_RD: begin
                    r_state <= ST_UPD;
                end
                ST_UPD: begin
                    r_est <= upd_est;
                    if (age_due) begin
                        r_phase <= '0;
                        r_state <= ST_AGE_RD;
                    end else begin
                        r_phase <= r_phase + 24'd1;
                        r_state <= ST_DONE;
                    end
                end
                ST_AGE_RD: begin
                    r_state <= ST_AGE_WR;
                end
                ST_AGE_WR: begin
                    r_cursor    <= (32'(r_cursor) == 32'(SKETCH_BLOCKS - 1)) ? 10'd0
                                                                            : r_cursor + 10'd1;
                    r_aging_tot <= r_aging_tot + 64'd1;
                    r_state     <= ST_DONE;
                end
                ST_DONE: begin
                    r_out.admit        <= is_query && ok;
                    r_out.estimate     <= r_est;
                    r_out.admissions   <= r_admit_tot + {63'd0, is_query && ok};
                    r_out.bypasses     <= r_bypass_tot + {63'd0, is_query && !ok};
                    r_out.thr_bypasses <= r_benefit_tot
                                          + {63'd0, is_query && !ok && thr};
                    r_out.age_count    <= r_aging_tot;
                    if (is_query) begin
                        if (ok) begin
                            r_admit_tot <= r_admit_tot + 64'd1;
                        end else begin
                            r_bypass_tot <= r_bypass_tot + 64'd1;
                            if (thr) begin
                                r_benefit_tot <= r_benefit_tot + 64'd1;
                            end
                        end
                    end
                    r_clr_op <= 1'b0;
                    r_done   <= 1'b1;
                    r_state  <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // a result word only appears as the sequencer returns to idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_state == ST_IDLE))
        else $error("result strobe outside idle return");

    // the sketch is never written while the block reports not busy
    a_no_idle_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy |-> !ram_we)
        else $error("sketch write while idle");

    // an admit needs a nonzero estimate unless the threshold admits always
    a_admit_est: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && r_out.admit) |-> (r_out.estimate != 4'd0 || r_min_acc == 4'd1))
        else $error("admit with zero estimate");

    // accepting an item always leaves idle on the next edge
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("item accepted but block stayed idle");

endmodule

>>> verif/testbench.sv
// Self-checking testbench for sketch_cache_line_admission_top.
// Needs scla_pkg; holds its own sketch predictor and checks every result word.
`timescale 1ns / 1ps

module testbench;
    import scla_pkg::*;

    localparam int ROWS = SKETCH_BLOCKS;

    logic           i_clk;
    logic           i_rst_n;
    logic           start;
    logic           busy;
    t_item          i_item;
    logic           o_done;
    t_result        o_result;
    logic           i_cfg_valid;
    logic           o_cfg_ready;
    logic [2:0]     i_cfg_index;
    logic [31:0]    i_cfg_data;

    sketch_cache_line_admission_top dut (.*);

    always #5 i_clk = ~i_clk;

    // predictor state
    logic [511:0]   sk_rows [ROWS];
    logic [23:0]    req_phase;
    logic [9:0]     age_cursor;
    logic [63:0]    n_admit, n_bypass, n_benefit, n_aged;
    logic [30:0]    cf_line;
    logic [23:0]    cf_period;
    logic [3:0]     cf_min;
    logic [31:0]    cf_hit, cf_fill;

    t_result        pending_q [$];
    int             n_errors;
    bit             quiet_sender;

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        $display("MISMATCH %s: got %0h want %0h at %0t", what, got, want, $realtime);
        n_errors++;
    endtask

    function automatic logic [63:0] mix64(logic [63:0] v);
        v = v + GOLDEN;
        v = (v ^ (v >> 30)) * MIX_C1;
        v = (v ^ (v >> 27)) * MIX_C2;
        return v ^ (v >> 31);
    endfunction

    function automatic void clear_sketch();
        foreach (sk_rows[r]) sk_rows[r] = '0;
        req_phase  = '0;
        age_cursor = '0;
    endfunction

    // estimate, count-min raise and aging for one request
    function automatic logic [3:0] sketch_touch(logic [63:0] offset);
        logic [63:0] key, h;
        logic [9:0]  row;
        logic [6:0]  slot [4];
        logic [3:0]  low;
        logic [31:0] per;
        key = offset / ((cf_line == 31'd0) ? 64'd1 : {33'd0, cf_line});
        h   = mix64(key);
        row = h[9:0];
        low = NIB_MAX;
        for (int i = 0; i < 4; i++) begin
            h = mix64(key ^ SLOT_SEED[i]);
            slot[i] = h[6:0];
            if (sk_rows[row][slot[i]*4 +: 4] < low) low = sk_rows[row][slot[i]*4 +: 4];
        end
        if (low != NIB_MAX)
            for (int i = 0; i < 4; i++)
                if (sk_rows[row][slot[i]*4 +: 4] == low)
                    sk_rows[row][slot[i]*4 +: 4] = low + 4'd1;
        per = (cf_period == 24'd0) ? 32'd1 : {8'd0, cf_period};
        if ({8'd0, req_phase} + 32'd1 >= per) begin
            for (int n = 0; n < 128; n++)
                sk_rows[age_cursor][n*4 +: 4] = sk_rows[age_cursor][n*4 +: 4] >> 1;
            age_cursor = age_cursor + 10'd1;
            req_phase  = '0;
            n_aged     = n_aged + 64'd1;
        end else begin
            req_phase = req_phase + 24'd1;
        end
        return low;
    endfunction

    function automatic t_result filter_step(t_item it);
        t_result     r;
        logic [63:0] saving, extra;
        logic        thr;
        r = '0;
        if (it.opcode == OP_QUERY) begin
            r.estimate = sketch_touch(it.byte_pos);
            saving = (it.bypass_time_ns > cf_hit) ? {32'd0, it.bypass_time_ns - cf_hit}
                                                  : 64'd0;
            extra  = (cf_fill > it.bypass_time_ns) ? {32'd0, cf_fill - it.bypass_time_ns}
                                                   : 64'd0;
            thr    = ({1'b0, r.estimate} + 5'd1) >= {1'b0, cf_min};
            if (cf_min == 4'd1 || (thr && r.estimate != 4'd0 && saving != 64'd0
                                   && {60'd0, r.estimate} * saving >= extra)) begin
                r.admit = 1'b1;
                n_admit = n_admit + 64'd1;
            end else begin
                n_bypass = n_bypass + 64'd1;
                if (thr) n_benefit = n_benefit + 64'd1;
            end
        end else if (it.opcode == OP_HIT) begin
            r.estimate = sketch_touch(it.byte_pos);
        end else if (it.opcode == OP_CLEAR) begin
            clear_sketch();
        end
        r.admissions   = n_admit;
        r.bypasses     = n_bypass;
        r.thr_bypasses = n_benefit;
        r.age_count    = n_aged;
        return r;
    endfunction

    // result words cannot be held off: take each one on its strobe
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (pending_q.size() == 0) begin
                report("unexpected word", o_result.estimate, 0);
            end else begin
                t_result w;
                w = pending_q.pop_front();
                if (o_result.admit != w.admit) report("admit", o_result.admit, w.admit);
                if (o_result.estimate != w.estimate)
                    report("estimate", o_result.estimate, w.estimate);
                if (o_result.admissions != w.admissions)
                    report("admissions", o_result.admissions, w.admissions);
                if (o_result.bypasses != w.bypasses)
                    report("bypasses", o_result.bypasses, w.bypasses);
                if (o_result.thr_bypasses != w.thr_bypasses)
                    report("thr_bypasses", o_result.thr_bypasses, w.thr_bypasses);
                if (o_result.age_count != w.age_count)
                    report("age_count", o_result.age_count, w.age_count);
            end
        end
    end

    // called right after a rising edge; leaves start high for a following word unless it pauses at random
    task automatic send_word(t_item it, bit typed, logic adm, logic [3:0] est);
        t_result r;
        start  <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        r = filter_step(it);
        if (typed) begin
            r.admit    = adm;
            r.estimate = est;
        end
        pending_q.push_back(r);
        if (!quiet_sender && $urandom_range(0, 5) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_q.size() != 0 || busy) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_LINE_BYTES: cf_line   = val[30:0];
            CFG_AGING_PER:  cf_period = val[23:0];
            CFG_MIN_ACC:    cf_min    = val[3:0];
            CFG_HIT_TIME:   cf_hit    = val;
            CFG_FILL_TIME:  cf_fill   = val;
            default: ;
        endcase
    endtask

    task automatic pick_settings(int ph);
        logic [31:0] v;
        case ($urandom_range(0, 6))
            0: v = 0;  1: v = 1;  2: v = 64;  3: v = 32'h4000_0000;
            4: v = 32'h7fff_ffff;  5: v = 4096;  default: v = $urandom_range(1, 100000);
        endcase
        if (ph == 0) v = 0;
        if (ph == 1) v = 32'h7fff_ffff;
        write_reg(CFG_LINE_BYTES, v);
        case ($urandom_range(0, 5))
            0: v = 0;  1: v = 1;  2: v = 3;  3: v = 32'h00ff_ffff;
            default: v = $urandom_range(2, 40);
        endcase
        if (ph == 0) v = 0;
        if (ph == 2) v = 32'hff00_0001;
        write_reg(CFG_AGING_PER, v);
        case ($urandom_range(0, 5))
            0: v = 0;  1: v = 1;  2: v = 15;  default: v = $urandom_range(2, 5);
        endcase
        if (ph == 1) v = 32'hffff_fff0;
        if (ph == 3) v = 15;
        write_reg(CFG_MIN_ACC, v);
        case ($urandom_range(0, 3))
            0: v = 0;  1: v = 32'hffff_ffff;  2: v = $urandom;  default: v = $urandom_range(0, 200);
        endcase
        write_reg(CFG_HIT_TIME, v);
        case ($urandom_range(0, 3))
            0: v = 0;  1: v = 32'hffff_ffff;  2: v = $urandom;  default: v = $urandom_range(0, 600);
        endcase
        write_reg(CFG_FILL_TIME, v);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic t_item random_word();
        t_item       it;
        int          pick;
        logic [63:0] lb;
        pick = $urandom_range(0, 99);
        it.opcode = (pick < 3) ? OP_CLEAR : (pick < 8) ? OP_UNUSED
                  : (pick < 35) ? OP_HIT : OP_QUERY;
        lb = (cf_line == 31'd0) ? 64'd1 : {33'd0, cf_line};
        // mostly a small set of lines so counts climb; some wide offsets
        if ($urandom_range(0, 9) == 0)
            it.byte_pos = {$urandom, $urandom};
        else
            it.byte_pos = lb * $urandom_range(0, 11) + ({$urandom, $urandom} % lb);
        it.bypass_time_ns = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 300);
        return it;
    endfunction

    typedef struct {
        logic [1:0]  op;
        logic [63:0] offset;
        logic [31:0] bypass;
        int          reps;
        bit          typed;
        logic        adm;
        logic [3:0]  est;
    } t_row;

    // reset settings: 64 KiB lines, period 1024, two accesses, zero hit/fill time
    t_row script [] = '{
        '{OP_QUERY,  64'd0,        32'd5,         1, 1, 1'b0, 4'd0},
        '{OP_QUERY,  64'd100,      32'd5,         1, 1, 1'b1, 4'd1},
        '{OP_HIT,    64'd200,      32'd0,         1, 1, 1'b0, 4'd2},
        '{OP_QUERY,  '1,           32'hffff_ffff, 1, 1, 1'b0, 4'd0},
        '{OP_QUERY,  '1,           32'hffff_ffff, 1, 1, 1'b1, 4'd1},
        '{OP_UNUSED, 64'h5555_aaaa_5555_aaaa, 32'h1234, 1, 1, 1'b0, 4'd0},
        '{OP_CLEAR,  64'd0,        32'd0,         1, 1, 1'b0, 4'd0},
        '{OP_QUERY,  64'd0,        32'd0,         1, 1, 1'b0, 4'd0},
        '{OP_QUERY,  64'd7,        32'd0,         1, 1, 1'b0, 4'd1},
        '{OP_HIT,    64'h5_0000,   32'd9,        17, 0, 1'b0, 4'd0},
        '{OP_QUERY,  64'h5_0001,   32'd10,        1, 1, 1'b1, 4'd15},
        '{OP_QUERY,  64'h9_0000,   32'd1,         3, 0, 1'b0, 4'd0}
    };

    initial begin
        t_item it;
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_item = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        n_errors = 0;
        quiet_sender = 1'b0;
        clear_sketch();
        {n_admit, n_bypass, n_benefit, n_aged} = '0;
        cf_line = 31'd65536; cf_period = 24'd1024; cf_min = 4'd2;
        cf_hit = '0; cf_fill = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // the block zeroes its sketch after reset
        while (busy) @(posedge i_clk);

        foreach (script[k])
            for (int r = 0; r < script[k].reps; r++) begin
                it = '{script[k].op, script[k].offset, script[k].bypass};
                send_word(it, script[k].typed, script[k].adm, script[k].est);
            end

        for (int ph = 0; ph < 8; ph++) begin
            drain();
            pick_settings(ph);
            quiet_sender = (ph == 7);
            for (int n = 0; n < 90; n++) begin
                send_word(random_word(), 0, 1'b0, 4'd0);
                if (ph == 3 && n == 45) drain();
            end
        end

        start <= 1'b0;
        @(posedge i_clk);
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (n_errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial begin
        #30ms;
        $display("Test completed with failures");
        $finish;
    end

endmodule
